// File: src/assert_macros.svh
// Assertion macros shared by the checker files of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset cycles included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/gne_pkg.sv
// Shared constants, types and codes of the grid neighbor expander.
`timescale 1ns / 1ps
package gne_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int CFG_W   = 9;
  localparam int DIM_MAX = (COL_W > ROW_W) ? COL_W : ROW_W;
  // Signed-free coordinate math: one spare bit so x-1 at column 0 wraps above any size.
  localparam int DIM_W   = ((DIM_MAX > CFG_W) ? DIM_MAX : CFG_W) + 1;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [7:0] CHAR_DOT = 8'h2E;
  localparam logic [7:0] CHAR_G   = 8'h47;
  localparam logic [7:0] CHAR_S   = 8'h53;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [1:0] {
    REG_MAP_WIDTH   = 2'd0,
    REG_MAP_HEIGHT  = 2'd1,
    REG_EIGHT_MODE  = 2'd2,
    REG_CORNER_RULE = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_QUERY = 2'd1,
    OP_MISS  = 2'd2
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] x;
    logic [7:0] y;
    logic       cell_free;
  } op_t;

  typedef struct packed {
    logic [DIM_W-1:0] eff_width;
    logic [DIM_W-1:0] eff_height;
    logic             eight_mode;
    logic             corner_rule;
  } cfg_t;

endpackage

// File: src/grid_neighbor_expander_unit.sv
// Top level of the grid neighbor expander: config registers, front end, queue, back end.
`timescale 1ns / 1ps
// The unit holds a one-bit occupancy map (MAX_WIDTH x MAX_HEIGHT, one memory row
// per map row) and answers neighbor queries on it. A load item (cmd 0) marks one
// cell free for '.', 'G' or 'S' and blocked for anything else; loads outside the
// configured size are dropped and give no result. A query item (cmd 1) returns
// the free neighbors of a free cell in the order N, S, W, E, then NW, NE, SW, SE
// when eight-neighbor mode is on, with last on the final one; under the corner
// rule a diagonal needs both adjacent cardinal cells free. A blocked, outside or
// isolated cell gives a single not-valid result with last set. The front end
// classifies each item in the cycle it is accepted and pushes it into a
// two-entry queue, so while it has room input transfers continue as the back
// end works or the output is stalled. The back end writes a load in its idle
// state, sends an outside query straight to its result and passes a query inside
// the map through three row reads, a drain and an evaluation; the single read
// port of the map memory fetches the three rows around the cell one per cycle.
// Every row starts blocked after reset through per-row valid bits, so there is
// no clearing pass and the unit takes items right after reset. Width and height
// above MAX_WIDTH / MAX_HEIGHT saturate; resizing keeps the stored cells.
// Write the configuration registers only while the unit is idle.
module grid_neighbor_expander_unit import gne_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_cmd,
  input  logic [7:0]        in_cell_x,
  input  logic [7:0]        in_cell_y,
  input  logic [7:0]        in_map_char,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_neighbor_x,
  output logic [7:0]        out_neighbor_y,
  output logic              out_neighbor_valid,
  output logic              out_last,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [CFG_W-1:0] map_width_r;
  logic [CFG_W-1:0] map_height_r;
  logic             eight_mode_r;
  logic             corner_rule_r;

  reg_idx_t         reg_idx;
  logic             cfg_wr;
  cfg_t             cfg;
  logic [DIM_W-1:0] width_ext, height_ext;

  logic q_full, q_push, q_pop, q_empty;
  op_t  q_op, q_head;

  // Register access: a transfer completes in the access phase, no wait states.
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r   <= CFG_W'(256);
      map_height_r  <= CFG_W'(256);
      eight_mode_r  <= 1'b1;
      corner_rule_r <= 1'b1;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_MAP_WIDTH:   map_width_r   <= pwdata[CFG_W-1:0];
        REG_MAP_HEIGHT:  map_height_r  <= pwdata[CFG_W-1:0];
        REG_EIGHT_MODE:  eight_mode_r  <= pwdata[0];
        REG_CORNER_RULE: corner_rule_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MAP_WIDTH:   prdata = DATA_W'(map_width_r);
      REG_MAP_HEIGHT:  prdata = DATA_W'(map_height_r);
      REG_EIGHT_MODE:  prdata = DATA_W'(eight_mode_r);
      REG_CORNER_RULE: prdata = DATA_W'(corner_rule_r);
      default:         prdata = '0;
    endcase
  end

  // Saturate the map size to the memory; a size of zero leaves every cell outside.
  assign width_ext  = DIM_W'(map_width_r);
  assign height_ext = DIM_W'(map_height_r);

  always_comb begin
    cfg.eff_width   = (width_ext > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_ext;
    cfg.eff_height  = (height_ext > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_ext;
    cfg.eight_mode  = eight_mode_r;
    cfg.corner_rule = corner_rule_r;
  end

  gne_front u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_cmd      (in_cmd),
    .in_cell_x   (in_cell_x),
    .in_cell_y   (in_cell_y),
    .in_map_char (in_map_char),
    .cfg         (cfg),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_op        (q_op)
  );

  gne_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (q_op),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .head    (q_head)
  );

  gne_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .q_empty            (q_empty),
    .q_head             (q_head),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_neighbor_x     (out_neighbor_x),
    .out_neighbor_y     (out_neighbor_y),
    .out_neighbor_valid (out_neighbor_valid),
    .out_last           (out_last)
  );

endmodule

// File: src/gne_front.sv
// Front end: accepts input items, checks bounds and classifies them into queue ops.
`timescale 1ns / 1ps
module gne_front import gne_pkg::*; (
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_cmd,
  input  logic [7:0] in_cell_x,
  input  logic [7:0] in_cell_y,
  input  logic [7:0] in_map_char,
  input  cfg_t       cfg,
  input  logic       q_full,
  output logic       q_push,
  output op_t        q_op
);

  logic accept;
  logic in_bounds;
  logic char_free;

  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign in_bounds = (DIM_W'(in_cell_x) < cfg.eff_width) &&
                     (DIM_W'(in_cell_y) < cfg.eff_height);
  assign char_free = (in_map_char == CHAR_DOT) || (in_map_char == CHAR_G) ||
                     (in_map_char == CHAR_S);

  // Drop loads outside the map; a query outside the map needs no memory access.
  assign q_push = accept && ((in_cmd == CMD_QUERY) || in_bounds);

  always_comb begin
    q_op.x         = in_cell_x;
    q_op.y         = in_cell_y;
    q_op.cell_free = char_free;
    if (in_cmd == CMD_LOAD) begin
      q_op.kind = OP_LOAD;
    end else if (in_bounds) begin
      q_op.kind = OP_QUERY;
    end else begin
      q_op.kind = OP_MISS;
    end
  end

endmodule

// File: src/gne_queue.sv
// Two-entry op queue between the front end and the back end.
`timescale 1ns / 1ps
module gne_queue import gne_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output logic empty,
  output op_t  head
);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  op_t               entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = (count_r == QCNT_W'(QDEPTH));
  assign empty   = (count_r == '0);
  assign head    = entry_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

// File: src/gne_back.sv
// Back end: map memory, three-row neighborhood fetch and result sequencer.
`timescale 1ns / 1ps
module gne_back import gne_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       q_empty,
  input  op_t        q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_neighbor_x,
  output logic [7:0] out_neighbor_y,
  output logic       out_neighbor_valid,
  output logic       out_last
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_READ  = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_EVAL  = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  localparam logic [2:0] DIR_N  = 3'd0;
  localparam logic [2:0] DIR_S  = 3'd1;
  localparam logic [2:0] DIR_W  = 3'd2;
  localparam logic [2:0] DIR_E  = 3'd3;
  localparam logic [2:0] DIR_NW = 3'd4;
  localparam logic [2:0] DIR_NE = 3'd5;
  localparam logic [2:0] DIR_SW = 3'd6;
  localparam logic [2:0] DIR_SE = 3'd7;
  localparam logic [1:0] LAST_ROW = 2'd2;

  logic [MAX_WIDTH-1:0]  map_mem [MAX_HEIGHT];
  logic [MAX_HEIGHT-1:0] row_vld_r;

  state_t           state_r, state_nxt;
  logic [1:0]       k_r, k_nxt;
  logic [7:0]       mask_r, mask_nxt;
  op_t              cur_r;
  logic [MAX_WIDTH-1:0] rd_row_r;
  logic             rd_ok_r;
  logic             cap_vld_r;
  logic [1:0]       cap_k_r;
  logic [2:0][2:0]  nb_r;

  logic             mem_we, rd_en, out_load;
  logic [ROW_W-1:0] wr_row;
  logic [COL_W-1:0] wr_col;
  logic [MAX_WIDTH-1:0] wr_fill;
  logic [DIM_W-1:0] rd_ry;
  logic [ROW_W-1:0] rd_row_idx;
  logic             rd_ok_nxt;
  logic [2:0]       cap_bits;
  logic [7:0]       eval_mask, sel_onehot, mask_rest;
  logic [2:0]       sel_dir;
  logic [7:0]       nb_x, nb_y;

  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_x_r, out_y_r;
  logic             out_nv_r, out_last_r;

  // Load write: a row never written before is filled whole so stale bits vanish.
  assign wr_row  = ROW_W'(q_head.y);
  assign wr_col  = COL_W'(q_head.x);
  assign wr_fill = MAX_WIDTH'(q_head.cell_free) << wr_col;

  // Row fetch for the query: rows y-1, y, y+1 in that order.
  assign rd_ry      = DIM_W'(cur_r.y) + DIM_W'(k_r) - DIM_W'(1);
  assign rd_row_idx = ROW_W'(rd_ry);
  assign rd_ok_nxt  = (rd_ry < cfg.eff_height) && row_vld_r[rd_row_idx];

  always_comb begin
    logic [DIM_W-1:0] col;
    cap_bits = '0;
    for (int j = 0; j < 3; j++) begin
      col = DIM_W'(cur_r.x) + DIM_W'(j) - DIM_W'(1);
      cap_bits[j] = rd_ok_r && (col < cfg.eff_width) && rd_row_r[COL_W'(col)];
    end
  end

  // Neighborhood evaluation: nb_r[row][col], row 0 is north, col 0 is west.
  always_comb begin
    logic fn, fs, fw, fe;
    fn = nb_r[0][1];
    fs = nb_r[2][1];
    fw = nb_r[1][0];
    fe = nb_r[1][2];
    eval_mask         = '0;
    eval_mask[DIR_N]  = fn;
    eval_mask[DIR_S]  = fs;
    eval_mask[DIR_W]  = fw;
    eval_mask[DIR_E]  = fe;
    if (cfg.eight_mode) begin
      eval_mask[DIR_NW] = nb_r[0][0] && (!cfg.corner_rule || (fn && fw));
      eval_mask[DIR_NE] = nb_r[0][2] && (!cfg.corner_rule || (fn && fe));
      eval_mask[DIR_SW] = nb_r[2][0] && (!cfg.corner_rule || (fs && fw));
      eval_mask[DIR_SE] = nb_r[2][2] && (!cfg.corner_rule || (fs && fe));
    end
    if (!nb_r[1][1]) begin
      eval_mask = '0;
    end
  end

  // Pick the lowest pending direction.
  assign sel_onehot = mask_r & (~mask_r + 8'd1);
  assign mask_rest  = mask_r & ~sel_onehot;

  always_comb begin
    sel_dir = '0;
    for (int i = 0; i < 8; i++) begin
      if (sel_onehot[i]) begin
        sel_dir = 3'(i);
      end
    end
  end

  always_comb begin
    unique case (sel_dir) inside
      DIR_W, DIR_NW, DIR_SW: nb_x = cur_r.x - 8'd1;
      DIR_E, DIR_NE, DIR_SE: nb_x = cur_r.x + 8'd1;
      default:               nb_x = cur_r.x;
    endcase
    unique case (sel_dir) inside
      DIR_N, DIR_NW, DIR_NE: nb_y = cur_r.y - 8'd1;
      DIR_S, DIR_SW, DIR_SE: nb_y = cur_r.y + 8'd1;
      default:               nb_y = cur_r.y;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    mask_nxt  = mask_r;
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    rd_en     = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          unique case (q_head.kind)
            OP_LOAD:  mem_we = 1'b1;
            OP_QUERY: begin
              state_nxt = ST_READ;
              k_nxt     = '0;
            end
            OP_MISS: begin
              state_nxt = ST_EMIT;
              mask_nxt  = '0;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        rd_en = 1'b1;
        k_nxt = k_r + 2'd1;
        if (k_r == LAST_ROW) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_EVAL;
      ST_EVAL: begin
        mask_nxt  = eval_mask;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        out_load = !out_valid_r || !out_stall;
        if (out_load) begin
          mask_nxt = mask_rest;
          if (mask_rest == '0) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      cap_vld_r   <= 1'b0;
      row_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      cap_vld_r   <= rd_en;
      out_valid_r <= out_valid_nxt;
      if (mem_we) begin
        row_vld_r[wr_row] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      if (row_vld_r[wr_row]) begin
        map_mem[wr_row][wr_col] <= q_head.cell_free;
      end else begin
        map_mem[wr_row] <= wr_fill;
      end
    end
    if (rd_en) begin
      rd_row_r <= map_mem[rd_row_idx];
    end
  end

  always_ff @(posedge clk) begin
    mask_r <= mask_nxt;
    if (q_pop) begin
      cur_r <= q_head;
    end
    if (rd_en) begin
      rd_ok_r <= rd_ok_nxt;
      cap_k_r <= k_r;
    end
    if (cap_vld_r) begin
      nb_r[cap_k_r] <= cap_bits;
    end
    if (out_load) begin
      if (mask_r == '0) begin
        out_x_r    <= '0;
        out_y_r    <= '0;
        out_nv_r   <= 1'b0;
        out_last_r <= 1'b1;
      end else begin
        out_x_r    <= nb_x;
        out_y_r    <= nb_y;
        out_nv_r   <= 1'b1;
        out_last_r <= (mask_rest == '0);
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_neighbor_x     = out_x_r;
  assign out_neighbor_y     = out_y_r;
  assign out_neighbor_valid = out_nv_r;
  assign out_last           = out_last_r;

endmodule

// File: src/gne_checker.sv
// Port-level checker of the grid neighbor expander, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gne_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_neighbor_x,
  input logic [7:0] out_neighbor_y,
  input logic       out_neighbor_valid,
  input logic       out_last
);

  logic miss_shape_ok;

  assign miss_shape_ok = out_last && (out_neighbor_x == 8'd0) && (out_neighbor_y == 8'd0);

  // A stalled result stays offered.
  `ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped under stall")

  // A not-valid result ends its query and carries zero coordinates.
  `ASSERT_CLK(a_miss_form, out_valid && !out_neighbor_valid |-> miss_shape_ok, "bad miss result")

  // Reset empties the output register and the queue.
  `ASSERT_ALWAYS(a_rst_out, !rst_n |=> !out_valid, "result offered after reset")
  `ASSERT_ALWAYS(a_rst_in, !rst_n |=> !in_stall, "input stalled after reset")

endmodule

bind grid_neighbor_expander_unit gne_checker u_gne_checker (.*);

// File: verif/tb_grid_neighbor_expander_unit.sv
// Self-checking testbench for the grid neighbor expander unit.
`timescale 1ns / 1ps
module tb_grid_neighbor_expander_unit;
  import gne_pkg::*;

  // Cycles with no transfer and no register access before the run is abandoned.
  // The slowest correct gap is a queued query behind a stalled output, or the
  // idle hold before a register write; this is far above.
  localparam int QUIET_LIMIT = 5000;
  // Cycles to hold after the last result so trailing loads leave the queue.
  localparam int SETTLE_CYCLES = 20;

  typedef struct {
    logic [7:0] nx;
    logic [7:0] ny;
    logic       nvalid;
    logic       last;
  } nbr_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_cmd = CMD_LOAD;
  logic [7:0]        in_cell_x = '0;
  logic [7:0]        in_cell_y = '0;
  logic [7:0]        in_map_char = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [7:0]        out_neighbor_x;
  logic [7:0]        out_neighbor_y;
  logic              out_neighbor_valid;
  logic              out_last;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // Shadow of the unit: occupancy bits and the four registers.
  bit          occ_map [0:MAX_WIDTH*MAX_HEIGHT-1];
  logic [8:0]  map_w_reg = 9'd256;
  logic [8:0]  map_h_reg = 9'd256;
  logic        eight_reg = 1'b1;
  logic        corner_reg = 1'b1;

  nbr_result_t nbr_expect_q[$];
  int          mismatches = 0;
  int          quiet_cycles = 0;
  // Set to switch off all random idling on both channels.
  bit          no_idle = 1'b0;

  grid_neighbor_expander_unit u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_cell_x          (in_cell_x),
    .in_cell_y          (in_cell_y),
    .in_map_char        (in_map_char),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_neighbor_x     (out_neighbor_x),
    .out_neighbor_y     (out_neighbor_y),
    .out_neighbor_valid (out_neighbor_valid),
    .out_last           (out_last),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Neighbor predictor
  // ---------------------------------------------------------------------------

  // Clip a size register to the map memory bound.
  function automatic int clip_dim(input logic [8:0] value, input int bound);
    return (int'(value) > bound) ? bound : int'(value);
  endfunction

  // Free and inside the current map; coordinates may run off either edge.
  function automatic bit cell_open(input int x, input int y);
    if (x < 0 || y < 0) return 1'b0;
    if (x >= clip_dim(map_w_reg, MAX_WIDTH) || y >= clip_dim(map_h_reg, MAX_HEIGHT))
      return 1'b0;
    return occ_map[y * MAX_WIDTH + x];
  endfunction

  // Append one expected result behind the ones already waiting.
  function automatic void queue_expected(input nbr_result_t r);
    nbr_expect_q = {nbr_expect_q, r};
  endfunction

  // Apply one accepted item to the shadow map and queue the results it causes.
  function automatic void expand_cell(input logic cmd, input logic [7:0] cx,
                                      input logic [7:0] cy, input logic [7:0] ch);
    int          x;
    int          y;
    int          n;
    int          px[8];
    int          py[8];
    bit          fn, fs, fw, fe, strict;
    nbr_result_t r;
    x = int'(cx);
    y = int'(cy);
    n = 0;
    if (cmd == CMD_LOAD) begin
      // Drop loads that fall outside the current size.
      if (x < clip_dim(map_w_reg, MAX_WIDTH) && y < clip_dim(map_h_reg, MAX_HEIGHT))
        occ_map[y * MAX_WIDTH + x] = (ch == CHAR_DOT) || (ch == CHAR_G) || (ch == CHAR_S);
      return;
    end
    if (cell_open(x, y)) begin
      fn = cell_open(x, y - 1);
      fs = cell_open(x, y + 1);
      fw = cell_open(x - 1, y);
      fe = cell_open(x + 1, y);
      strict = corner_reg;
      if (fn) begin px[n] = x;     py[n] = y - 1; n++; end
      if (fs) begin px[n] = x;     py[n] = y + 1; n++; end
      if (fw) begin px[n] = x - 1; py[n] = y;     n++; end
      if (fe) begin px[n] = x + 1; py[n] = y;     n++; end
      if (eight_reg) begin
        if (cell_open(x - 1, y - 1) && (!strict || (fn && fw))) begin
          px[n] = x - 1; py[n] = y - 1; n++;
        end
        if (cell_open(x + 1, y - 1) && (!strict || (fn && fe))) begin
          px[n] = x + 1; py[n] = y - 1; n++;
        end
        if (cell_open(x - 1, y + 1) && (!strict || (fs && fw))) begin
          px[n] = x - 1; py[n] = y + 1; n++;
        end
        if (cell_open(x + 1, y + 1) && (!strict || (fs && fe))) begin
          px[n] = x + 1; py[n] = y + 1; n++;
        end
      end
    end
    if (n == 0) begin
      r.nx = '0;
      r.ny = '0;
      r.nvalid = 1'b0;
      r.last = 1'b1;
      queue_expected(r);
    end else begin
      for (int k = 0; k < n; k++) begin
        r.nx = px[k][7:0];
        r.ny = py[k][7:0];
        r.nvalid = 1'b1;
        r.last = (k == n - 1);
        queue_expected(r);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every result transfer is matched against the oldest
  // expectation. Sampling at the edge sees pre-edge values on both sides.
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string name, input int want, input int got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    nbr_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (nbr_expect_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual x=%0d y=%0d v=%0b last=%0b",
                 $time, out_neighbor_x, out_neighbor_y, out_neighbor_valid, out_last);
        mismatches++;
      end else begin
        want = nbr_expect_q.pop_front();
        check_field("neighbor_x", want.nx, out_neighbor_x);
        check_field("neighbor_y", want.ny, out_neighbor_y);
        check_field("neighbor_valid", want.nvalid, out_neighbor_valid);
        check_field("last", want.last, out_last);
      end
    end
  end

  // Randomly stall the result channel, except during quiet stretches.
  always @(posedge clk) begin
    out_stall <= !no_idle && ($urandom_range(99) < 36);
  end

  // Watchdog: abandon the run after too many cycles without any transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("grid_neighbor_expander_unit test failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Present one item, hold it until the unit takes it, then predict its results.
  // Valid stays high on return so back-to-back items need no extra edge.
  task automatic send_cell(input logic cmd, input logic [7:0] x, input logic [7:0] y,
                           input logic [7:0] ch);
    if (!no_idle) begin
      while ($urandom_range(99) < 36) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid    <= 1'b1;
    in_cmd      <= cmd;
    in_cell_x   <= x;
    in_cell_y   <= y;
    in_map_char <= ch;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expand_cell(cmd, x, y, ch);
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic hold_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (nbr_expect_q.size() != 0) @(posedge clk);
  endtask

  // One register write: setup cycle, then access cycle until pready.
  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MAP_WIDTH:   map_w_reg  = value[8:0];
      REG_MAP_HEIGHT:  map_h_reg  = value[8:0];
      REG_EIGHT_MODE:  eight_reg  = value[0];
      REG_CORNER_RULE: corner_reg = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Let the unit go idle, then rewrite all four registers.
  task automatic set_map(input logic [31:0] w, input logic [31:0] h,
                         input logic eight, input logic corner);
    hold_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write(REG_MAP_WIDTH, w);
    cfg_write(REG_MAP_HEIGHT, h);
    cfg_write(REG_EIGHT_MODE, {31'd0, eight});
    cfg_write(REG_CORNER_RULE, {31'd0, corner});
  endtask

  function automatic logic [7:0] any_free_char();
    case ($urandom_range(2))
      0:       return CHAR_DOT;
      1:       return CHAR_G;
      default: return CHAR_S;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values: queries on a blocked map, free and blocked characters, the
  // corner rule against a blocked side, and the far map corner.
  task automatic test_single_cells();
    send_cell(CMD_QUERY, 8'd0, 8'd0, 8'h00);     // blocked after reset
    send_cell(CMD_LOAD,  8'd0, 8'd0, CHAR_DOT);
    send_cell(CMD_QUERY, 8'd0, 8'd0, 8'hFF);     // free but isolated
    send_cell(CMD_LOAD,  8'd1, 8'd0, CHAR_G);
    send_cell(CMD_LOAD,  8'd0, 8'd1, CHAR_S);
    send_cell(CMD_LOAD,  8'd1, 8'd1, 8'hFF);     // any other byte blocks
    send_cell(CMD_QUERY, 8'd0, 8'd0, 8'h00);
    send_cell(CMD_LOAD,  8'd1, 8'd1, CHAR_DOT);
    send_cell(CMD_QUERY, 8'd0, 8'd0, 8'h00);     // now with the diagonal
    send_cell(CMD_LOAD,  8'd0, 8'd0, 8'h2F);     // neighbor of '.' still blocks
    send_cell(CMD_QUERY, 8'd1, 8'd0, 8'h00);     // diagonal cut by the corner rule
    send_cell(CMD_LOAD,  8'd255, 8'd255, CHAR_DOT);
    send_cell(CMD_LOAD,  8'd254, 8'd255, CHAR_S);
    send_cell(CMD_QUERY, 8'd255, 8'd255, 8'h00); // east and south edges count blocked
  endtask

  // A fully free 3x3 block gives all eight neighbors; then cut one side and
  // walk through the corner rule and the four-neighbor mode.
  task automatic test_full_ring();
    for (int dy = 0; dy < 3; dy++)
      for (int dx = 0; dx < 3; dx++)
        send_cell(CMD_LOAD, 8'(100 + dx), 8'(100 + dy), any_free_char());
    send_cell(CMD_QUERY, 8'd101, 8'd101, 8'h00);
    send_cell(CMD_LOAD,  8'd101, 8'd100, 8'h23);
    send_cell(CMD_QUERY, 8'd101, 8'd101, 8'h00);
    set_map(32'd256, 32'd256, 1'b1, 1'b0);
    send_cell(CMD_QUERY, 8'd101, 8'd101, 8'h00);
    set_map(32'd256, 32'd256, 1'b0, 1'b0);
    send_cell(CMD_QUERY, 8'd101, 8'd101, 8'h00);
  endtask

  // Size registers: empty map, 1x1 map, a small map that hides stored cells
  // past its edge, and an oversized width that saturates.
  task automatic test_map_bounds();
    set_map(32'd256, 32'd256, 1'b1, 1'b1);
    send_cell(CMD_LOAD, 8'd7, 8'd7, CHAR_DOT);
    send_cell(CMD_LOAD, 8'd8, 8'd7, CHAR_DOT);
    send_cell(CMD_LOAD, 8'd6, 8'd7, CHAR_G);
    set_map(32'd0, 32'd0, 1'b1, 1'b1);
    send_cell(CMD_LOAD,  8'd5, 8'd5, CHAR_DOT);  // dropped on an empty map
    send_cell(CMD_QUERY, 8'd7, 8'd7, 8'h00);
    set_map(32'd1, 32'd1, 1'b1, 1'b1);
    send_cell(CMD_QUERY, 8'd0, 8'd0, 8'h00);     // only cell, no neighbors
    send_cell(CMD_QUERY, 8'd1, 8'd0, 8'h00);     // outside the map
    set_map(32'd8, 32'd8, 1'b1, 1'b1);
    send_cell(CMD_QUERY, 8'd7, 8'd7, 8'h00);     // (8,7) lies past the edge
    set_map(32'h0000_FFFF, 32'd256, 1'b1, 1'b1); // upper bits ignored, 511 saturates
    send_cell(CMD_QUERY, 8'd7, 8'd7, 8'h00);     // stored cells come back
  endtask

  // Random loads and queries clustered in a small window so queries meet
  // free neighbors; a tenth of the items are fully random noise.
  task automatic test_random_traffic(input logic [31:0] w, input logic [31:0] h,
                                     input logic eight, input logic corner,
                                     input int count, input bit quiet, input bit pause);
    int ew;
    int eh;
    int win_w;
    int win_h;
    int base_x;
    int base_y;
    int pick;
    logic [7:0] x;
    logic [7:0] y;
    set_map(w, h, eight, corner);
    ew = clip_dim(w[8:0], MAX_WIDTH);
    eh = clip_dim(h[8:0], MAX_HEIGHT);
    no_idle = quiet;
    win_w = (ew <= 12) ? ew + 1 : 8;
    win_h = (eh <= 12) ? eh + 1 : 8;
    base_x = 0;
    base_y = 0;
    for (int k = 0; k < count; k++) begin
      // Move the window now and then; favor the far edges on maps larger than 12.
      if (k % 25 == 0) begin
        if (ew > 12)
          base_x = ($urandom_range(3) == 0) ? ew - 8 :
                   $urandom_range(0, (ew < MAX_WIDTH) ? ew - 7 : ew - 8);
        if (eh > 12)
          base_y = ($urandom_range(3) == 0) ? eh - 8 :
                   $urandom_range(0, (eh < MAX_HEIGHT) ? eh - 7 : eh - 8);
      end
      // Hold off once mid-phase until every result is back.
      if (pause && k == count / 2)
        hold_for_results();
      x = 8'(base_x + $urandom_range(0, win_w - 1));
      y = 8'(base_y + $urandom_range(0, win_h - 1));
      pick = $urandom_range(99);
      if (pick < 10)
        send_cell(1'($urandom_range(1)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)));
      else if (pick < 55)
        send_cell(CMD_LOAD, x, y,
                  ($urandom_range(99) < 65) ? any_free_char() : 8'($urandom_range(255)));
      else
        send_cell(CMD_QUERY, x, y, 8'($urandom_range(255)));
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_cells();
    test_full_ring();
    test_map_bounds();
    // The first stretch runs with no idling on either side.
    test_random_traffic(32'd256, 32'd256, 1'b1, 1'b1, 70, 1'b1, 1'b0);
    test_random_traffic(32'd10,  32'd7,   1'b1, 1'b0, 55, 1'b0, 1'b0);
    test_random_traffic(32'd511, 32'd256, 1'b0, 1'b1, 55, 1'b0, 1'b1);
    test_random_traffic(32'd1,   32'd12,  1'b1, 1'b1, 40, 1'b0, 1'b0);
    test_random_traffic(32'd16,  32'd16,  1'b1, 1'b1, 45, 1'b0, 1'b0);

    // Drain, then leave room for anything the unit should not send.
    hold_for_results();
    repeat (30) @(posedge clk);
    if (mismatches == 0) begin
      $display("grid_neighbor_expander_unit test passed");
    end else begin
      $display("grid_neighbor_expander_unit test failed");
    end
    $finish;
  end

endmodule
